>>> src/ssr_pkg.sv
// ----------------------------------------------------------------------------
// Servo slew ramp package
// Shared types, register indexes and reset values for the servo slew ramp.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // Default number of servo channels in the ring.
    localparam int CHANNELS_DEF = 8;

    // At most this many results are reported per tick.
    localparam int MAX_RESULTS = 8;

    // Width of the reported result count.
    localparam int NOUT_W = $clog2(MAX_RESULTS + 1);

    // Position and target after reset.
    localparam logic [15:0] MID_WIDTH = 16'd1500;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_MAX_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_WIDTH_GAIN  = 3'd2;
    localparam logic [2:0] CFG_STEP_SIZE   = 3'd3;
    localparam logic [2:0] CFG_COUNT_LIMIT = 3'd4;

    // Configuration register reset values.
    localparam logic [15:0] MIN_WIDTH_RST   = 16'd1000;
    localparam logic [15:0] MAX_WIDTH_RST   = 16'd2000;
    localparam logic [15:0] WIDTH_GAIN_RST  = 16'd318;
    localparam logic [11:0] STEP_SIZE_RST   = 12'd35;
    localparam logic [7:0]  COUNT_LIMIT_RST = 8'd50;

    // Saturation value of the per-channel step count.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // State of one servo channel, as held in one cell of the ring.
    typedef struct packed {
        logic [15:0] position;
        logic [15:0] target;
        logic        armed;
        logic [7:0]  count;
    } t_chan;

    // Control of one cell: rotate the ring, or load a new target.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

>>> src/ssr_map.sv
// ----------------------------------------------------------------------------
// Servo slew ramp angle mapper
// Turns a signed Q3.12 angle into a clamped pulse width via a registered product.
// ----------------------------------------------------------------------------
module ssr_map
    import ssr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [15:0] i_angle,
    input  logic [15:0]        i_gain,
    input  logic [15:0]        i_min,
    input  logic [15:0]        i_max,
    output logic [15:0]        o_width
);

    logic signed [32:0] r_prod;
    logic signed [20:0] w_q;
    logic signed [22:0] w_sum;
    logic signed [22:0] w_min;
    logic signed [22:0] w_max;

    // Product of angle and gain, registered when a set-target transaction lands.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 33'(i_angle) * $signed({1'b0, i_gain});
        end
    end

    // Floor shift by 12, offset by the minimum, then clamp high and low.
    always_comb begin
        w_q   = r_prod[32:12];
        w_min = $signed({7'd0, i_min});
        w_max = $signed({7'd0, i_max});
        w_sum = {{2{w_q[20]}}, w_q} + w_min;
        if (w_sum > w_max) begin
            w_sum = w_max;
        end
        if (w_sum < w_min) begin
            w_sum = w_min;
        end
        o_width = w_sum[15:0];
    end

endmodule

>>> src/ssr_slew.sv
// ----------------------------------------------------------------------------
// Servo slew ramp step unit
// Moves the head channel one step toward its target, or snaps it there when near or out of steps.
// ----------------------------------------------------------------------------
module ssr_slew
    import ssr_pkg::*;
(
    input  t_chan       i_chan,
    input  logic [11:0] i_step,
    input  logic [7:0]  i_limit,
    output t_chan       o_chan
);

    logic [15:0] w_dist;
    logic        w_up;
    logic        w_snap;

    // Distance to target and the decision to snap.
    always_comb begin
        w_up   = i_chan.target > i_chan.position;
        w_dist = w_up ? (i_chan.target - i_chan.position)
                      : (i_chan.position - i_chan.target);
        w_snap = (w_dist <= {4'd0, i_step}) || (i_chan.count > i_limit);
    end

    // A channel that is not armed passes unchanged.
    always_comb begin
        o_chan = i_chan;
        if (i_chan.armed) begin
            if (w_snap) begin
                o_chan.position = i_chan.target;
                o_chan.armed    = 1'b0;
            end else begin
                o_chan.position = w_up ? (i_chan.position + {4'd0, i_step})
                                       : (i_chan.position - {4'd0, i_step});
                if (i_chan.count != COUNT_MAX) begin
                    o_chan.count = i_chan.count + 8'd1;
                end
            end
        end
    end

endmodule

>>> src/ssr_cell.sv
// ----------------------------------------------------------------------------
// Servo slew ramp cell
// Holds one channel's state and passes it to its neighbor when the ring turns.
// ----------------------------------------------------------------------------
module ssr_cell
    import ssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  t_chan       i_next,
    input  logic [15:0] i_target,
    output t_chan       o_chan
);

    t_chan r_chan;
    t_chan n_chan;

    // Rotate from the neighbor, or take a new target and arm.
    always_comb begin
        n_chan = r_chan;
        if (i_ctl.shift) begin
            n_chan = i_next;
        end else if (i_ctl.load) begin
            n_chan.target = i_target;
            n_chan.armed  = 1'b1;
            n_chan.count  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan.position <= MID_WIDTH;
            r_chan.target   <= MID_WIDTH;
            r_chan.armed    <= 1'b0;
            r_chan.count    <= 8'd0;
        end else begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

>>> src/servo_slew_ramp.sv
// ----------------------------------------------------------------------------
// Servo slew ramp
// Multi-channel servo slew limiter built as a rotating ring of channel cells.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_kind, i_channel, i_angle
//  out      output     o_out_valid / i_out_ready  o_out_channel, o_width, o_last
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  In a set-target transaction the multiplier product is registered, then the
//  clamped width is written into the channel's cell. A tick is accepted, then
//  the ring turns once per cycle and the step unit updates whichever channel
//  sits at its head. The ring holds while a result waits in the output register
//  and is not taken. Configuration writes are always taken.
//  Reset is synchronous and restores every cell at once; there is no clearing pass.
//
module servo_slew_ramp
    import ssr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [2:0]  i_channel,
    input  logic signed [15:0] i_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_out_channel,
    output logic [15:0] o_width,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CW-1:0]       r_scan;
    logic [CHANNELS-1:0] r_mask;
    logic [NOUT_W-1:0]   r_nout;
    logic [2:0]          r_ch;

    logic [15:0] r_min_width;
    logic [15:0] r_max_width;
    logic [15:0] r_width_gain;
    logic [11:0] r_step_size;
    logic [7:0]  r_count_limit;

    logic        r_out_valid;
    logic [2:0]  r_out_channel;
    logic [15:0] r_width;
    logic        r_last;

    logic        w_in_take;
    logic        w_adv;
    logic        w_emit;
    logic        w_later;
    logic        w_end;
    logic [15:0] w_map_width;
    logic [CHANNELS-1:0] w_armed;

    t_chan     w_cell [CHANNELS];
    t_chan     w_head_next;
    t_cell_ctl w_ctl  [CHANNELS];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_take   = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width   <= MIN_WIDTH_RST;
            r_max_width   <= MAX_WIDTH_RST;
            r_width_gain  <= WIDTH_GAIN_RST;
            r_step_size   <= STEP_SIZE_RST;
            r_count_limit <= COUNT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_WIDTH:   r_min_width   <= i_cfg_data;
                CFG_MAX_WIDTH:   r_max_width   <= i_cfg_data;
                CFG_WIDTH_GAIN:  r_width_gain  <= i_cfg_data;
                CFG_STEP_SIZE:   r_step_size   <= i_cfg_data[11:0];
                CFG_COUNT_LIMIT: r_count_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Angle to width mapping for set-target transactions.
    ssr_map u_map (
        .i_clk   (i_clk),
        .i_load  (w_in_take && !i_kind),
        .i_angle (i_angle),
        .i_gain  (r_width_gain),
        .i_min   (r_min_width),
        .i_max   (r_max_width),
        .o_width (w_map_width)
    );

    // Step unit at the head of the ring.
    ssr_slew u_slew (
        .i_chan  (w_cell[0]),
        .i_step  (r_step_size),
        .i_limit (r_count_limit),
        .o_chan  (w_head_next)
    );

    // Ring of cells: each takes its upper neighbor, the last takes the updated head.
    for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
        assign w_ctl[k].shift = (r_state == S_SCAN) && w_adv;
        assign w_ctl[k].load  = (r_state == S_MAP) && (5'(r_ch) == 5'(k));
        assign w_armed[k]     = w_cell[k].armed;

        ssr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[k]),
            .i_next   ((k == CHANNELS - 1) ? w_head_next : w_cell[(k + 1) % CHANNELS]),
            .i_target (w_map_width),
            .o_chan   (w_cell[k])
        );
    end

    // Scan control: advance only when the output register can take a result.
    always_comb begin
        w_adv   = !r_out_valid || i_out_ready;
        w_later = (r_mask >> 1) != '0;
        w_emit  = w_cell[0].armed && (r_nout < NOUT_W'(MAX_RESULTS));
        w_end   = (r_scan == CW'(CHANNELS - 1));
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = i_kind ? S_SCAN : S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (w_adv && w_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_mask  <= '0;
            r_nout  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_take && i_kind) begin
                r_scan <= '0;
                r_mask <= w_armed;
                r_nout <= '0;
            end else if ((r_state == S_SCAN) && w_adv) begin
                r_scan <= r_scan + CW'(1);
                r_mask <= r_mask >> 1;
                if (w_emit) begin
                    r_nout <= r_nout + NOUT_W'(1);
                end
            end
        end
    end

    // Channel of the set-target transaction in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_ch <= i_channel;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_SCAN) && w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_adv && w_emit) begin
            r_out_channel <= 3'(r_scan);
            r_width       <= w_head_next.position;
            r_last        <= !w_later || (r_nout == NOUT_W'(MAX_RESULTS - 1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_width       = r_width;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // The reported count never passes the per-tick limit.
    a_nout_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nout <= NOUT_W'(MAX_RESULTS))
        else $error("result count passed its limit");

    // A completed scan has shifted out every armed flag it captured.
    a_mask_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && w_adv && w_end |=> r_mask == '0)
        else $error("armed mask not drained at end of scan");

    // A tick transaction starts a scan with an empty result count.
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && i_kind |=> (r_state == S_SCAN) && (r_nout == '0) && (r_scan == '0))
        else $error("tick did not start a scan");

    // A set-target transaction never presents a result on its own.
    a_map_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) && !o_out_valid |=> !o_out_valid)
        else $error("result appeared after set target");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo slew ramp testbench
// Drives set-target and tick transactions into the slew limiter with random
// idling on both channels, predicts every pulse width update from a local
// model of the channel ring, and checks each output transaction in order.
// ----------------------------------------------------------------------------
module testbench;
    import ssr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 2 * CHANNELS_DEF + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 10;
    localparam int SAT_TICKS     = 258;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIR_ROWS      = 28;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    // One row of the directed table: an input transaction or a register write.
    typedef struct packed {
        t_row_op     op;
        logic        kind;
        logic [2:0]  sel;        // channel, or register index
        logic [15:0] value;      // angle, or register data
        logic        typed;      // expectation taken from the row itself
        logic        has_result;
        logic [2:0]  exp_ch;
        logic [15:0] exp_width;
    } t_dir_row;

    // One pulse width update as seen on the output channel.
    typedef struct packed {
        logic [2:0]  ch;
        logic [15:0] width;
        logic        last;
    } t_upd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [2:0]  i_channel = 3'd0;
    logic [15:0] i_angle = 16'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_out_channel;
    logic [15:0] o_width;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [15:0] i_cfg_data = 16'd0;

    // Local copy of the configuration and of the channel ring.
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [15:0] cfg_gain;
    logic [11:0] cfg_step;
    logic [7:0]  cfg_limit;
    t_chan       chans [CHANNELS_DEF];

    t_upd     tick_updates [$];
    t_upd     pending_updates [$];
    t_upd     head_update;
    t_dir_row dir_rows [DIR_ROWS];

    bit quiet = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;

    servo_slew_ramp #(
        .CHANNELS(CHANNELS_DEF)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_channel    (i_channel),
        .i_angle      (i_angle),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_channel(o_out_channel),
        .o_width      (o_width),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit, counted in clock cycles.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("servo_slew_ramp regression: fail");
            $finish;
        end
    end

    // Target width: floor of angle times gain over 4096, offset by the minimum,
    // clamped to the maximum first and to the minimum last.
    function automatic logic [15:0] angle_to_width(input logic signed [15:0] angle);
        longint prod;
        longint w;
        prod = longint'(angle) * longint'(cfg_gain);
        w = longint'(cfg_min) + (prod >>> 12);
        if (w > longint'(cfg_max)) w = longint'(cfg_max);
        if (w < longint'(cfg_min)) w = longint'(cfg_min);
        return w[15:0];
    endfunction

    // Apply one input transaction to the local ring and collect its updates.
    task automatic slew_predict(input logic kind, input logic [2:0] ch,
                                input logic [15:0] angle);
        t_chan       c;
        logic [15:0] span;
        t_upd        u;
        tick_updates.delete();
        if (kind == KIND_SET) begin
            chans[ch].target = angle_to_width(angle);
            chans[ch].armed  = 1'b1;
            chans[ch].count  = 8'd0;
        end else begin
            for (int i = 0; i < CHANNELS_DEF; i++) begin
                c = chans[i];
                if (c.armed) begin
                    span = (c.target >= c.position) ? c.target - c.position
                                                    : c.position - c.target;
                    // Close enough, or out of steps: snap and disarm.
                    if (span <= 16'(cfg_step) || c.count > cfg_limit) begin
                        c.position = c.target;
                        c.armed    = 1'b0;
                    end else begin
                        c.position = (c.target > c.position) ? c.position + 16'(cfg_step)
                                                             : c.position - 16'(cfg_step);
                        if (c.count != COUNT_MAX) c.count++;
                    end
                    chans[i] = c;
                    if (tick_updates.size() < MAX_RESULTS)
                        tick_updates.push_back('{3'(i), c.position, 1'b0});
                end
            end
            if (tick_updates.size() > 0) begin
                u = tick_updates.pop_back();
                u.last = 1'b1;
                tick_updates.push_back(u);
            end
        end
    endtask

    // Offer one input transaction; called at a falling edge and returns at one.
    task automatic send_item(input logic kind, input logic [2:0] ch,
                             input logic [15:0] angle, input logic typed,
                             input logic has_result, input t_upd typed_upd);
        int gap;
        gap = 0;
        if (!quiet) while ($urandom_range(99) < 8) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_channel  <= ch;
        i_angle    <= angle;
        do @(posedge i_clk); while (!o_in_ready);
        slew_predict(kind, ch, angle);
        if (!typed) begin
            foreach (tick_updates[j]) pending_updates.push_back(tick_updates[j]);
        end else if (has_result) begin
            pending_updates.push_back(typed_upd);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Write one register through the configuration channel.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_WIDTH:   cfg_min   = data;
            CFG_MAX_WIDTH:   cfg_max   = data;
            CFG_WIDTH_GAIN:  cfg_gain  = data;
            CFG_STEP_SIZE:   cfg_step  = data[11:0];
            CFG_COUNT_LIMIT: cfg_limit = data[7:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering input, drain every expected update, then let the ring settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_updates.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Output ready: random idling, plus long hold-offs when the sender asks.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_done < holds_asked) begin
            i_out_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done = holds_done + 1;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Compare each output transaction with the oldest expected update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected update: channel %0d width %0d last %0d",
                       o_out_channel, o_width, o_last);
                errors++;
            end else begin
                head_update = pending_updates.pop_front();
                results_seen++;
                if (o_out_channel !== head_update.ch) begin
                    $error("out_channel mismatch: expected %0d, actual %0d",
                           head_update.ch, o_out_channel);
                    errors++;
                end
                if (o_width !== head_update.width) begin
                    $error("width mismatch: expected %0d, actual %0d",
                           head_update.width, o_width);
                    errors++;
                end
                if (o_last !== head_update.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           head_update.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int          n;
        int          directed;
        logic        kind;
        logic [2:0]  ch;
        logic [15:0] ang;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] gn;
        logic [15:0] st;
        logic [15:0] lm;
        t_dir_row    r;

        // Reset configuration, with every channel parked at mid-scale.
        cfg_min   = MIN_WIDTH_RST;
        cfg_max   = MAX_WIDTH_RST;
        cfg_gain  = WIDTH_GAIN_RST;
        cfg_step  = STEP_SIZE_RST;
        cfg_limit = COUNT_LIMIT_RST;
        for (int i = 0; i < CHANNELS_DEF; i++)
            chans[i] = '{MID_WIDTH, MID_WIDTH, 1'b0, 8'd0};

        // Directed rows. Typed expectations hold right after reset only.
        dir_rows = '{
            // Tick with nothing armed gives no update.
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0, 16'd0},
            // Zero angle targets the minimum; one step down from mid-scale.
            '{ROW_ITEM, KIND_SET,  3'd0, 16'h0000, 1'b1, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b1, 1'b1, 3'd0, 16'd1465},
            // Angle extremes clamp to the width limits; small and negative ones.
            '{ROW_ITEM, KIND_SET,  3'd7, 16'h7FFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd3, 16'h8000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd1, 16'h0100, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd2, 16'hFFFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd5, 16'h1234, 1'b0, 1'b0, 3'd0, 16'd0},
            // Minimum above maximum: the target ends at the minimum.
            '{ROW_CFG,  KIND_SET,  CFG_MIN_WIDTH,   16'd3000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_MAX_WIDTH,   16'd100,  1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd4, 16'h3039, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            // Zero step: channels hold until the count limit snaps them.
            '{ROW_CFG,  KIND_SET,  CFG_STEP_SIZE,   16'd0,    1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_COUNT_LIMIT, 16'd1,    1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd7, 16'hFFFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            // Register extremes: full width range, full gain, largest step.
            '{ROW_CFG,  KIND_SET,  CFG_MIN_WIDTH,   16'd0,    1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_MAX_WIDTH,   16'hFFFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_WIDTH_GAIN,  16'hFFFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_STEP_SIZE,   16'h0FFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_CFG,  KIND_SET,  CFG_COUNT_LIMIT, 16'h00FF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd5, 16'h7FFF, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_SET,  3'd6, 16'h8000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0},
            '{ROW_ITEM, KIND_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 16'd0}
        };

        // Synchronous reset, asserted once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        for (int k = 0; k < DIR_ROWS; k++) begin
            r = dir_rows[k];
            if (r.op == ROW_CFG) begin
                wait_idle();
                write_reg(r.sel, r.value);
            end else begin
                send_item(r.kind, r.sel, r.value, r.typed, r.has_result,
                          '{r.exp_ch, r.exp_width, 1'b1});
            end
        end
        directed = items_sent;

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    mn = MIN_WIDTH_RST;
                    mx = MAX_WIDTH_RST;
                    gn = WIDTH_GAIN_RST;
                    st = 16'(STEP_SIZE_RST);
                    lm = 16'(COUNT_LIMIT_RST);
                end
                1: begin
                    mn = 16'($urandom_range(500, 1500));
                    mx = mn + 16'($urandom_range(0, 2000));
                    gn = 16'($urandom_range(100, 2000));
                    st = 16'($urandom_range(1, 100));
                    lm = 16'($urandom_range(0, 40));
                end
                2: begin
                    // Unit step with the count limit at its top: counts saturate.
                    mn = 16'd0;
                    mx = 16'hFFFF;
                    gn = 16'hFFFF;
                    st = 16'd1;
                    lm = 16'h00FF;
                end
                3: begin
                    mn = 16'($urandom_range(2000, 60000));
                    mx = 16'($urandom_range(0, mn - 1));
                    gn = 16'($urandom);
                    st = 16'd0;
                    lm = 16'($urandom_range(0, 5));
                end
                default: begin
                    mn = 16'($urandom);
                    mx = 16'($urandom);
                    gn = 16'($urandom);
                    st = 16'($urandom);
                    lm = 16'($urandom);
                end
            endcase
            write_reg(CFG_MIN_WIDTH, mn);
            write_reg(CFG_MAX_WIDTH, mx);
            write_reg(CFG_WIDTH_GAIN, gn);
            write_reg(CFG_STEP_SIZE, st);
            write_reg(CFG_COUNT_LIMIT, lm);
            quiet <= (ph == 1);

            n = (ph == 2) ? CHANNELS_DEF + SAT_TICKS : PHASE_ITEMS;
            for (int k = 0; k < n; k++) begin
                // Long output hold-off while input keeps coming.
                if (ph == 1 && k == 4) holds_asked <= holds_asked + 1;
                // Sender pause until every expected update has drained.
                if (ph == 3 && k == 5) wait_idle();
                if (ph == 2) begin
                    kind = (k < CHANNELS_DEF) ? KIND_SET : KIND_TICK;
                    ch   = 3'(k);
                    ang  = k[0] ? 16'h7FFF : 16'h8000;
                end else begin
                    kind = ($urandom_range(99) < 35) ? KIND_SET : KIND_TICK;
                    ch   = 3'($urandom_range(7));
                    ang  = $urandom_range(1) ? 16'($urandom)
                                             : 16'($urandom_range(0, 16383));
                end
                send_item(kind, ch, ang, 1'b0, 1'b0, '0);
            end
        end

        wait_idle();
        $display("Covered %0d input transactions (%0d directed) and %0d register writes,",
                 items_sent, directed, cfg_writes);
        $display("with %0d width updates checked across five register settings.",
                 results_seen);
        if (errors == 0)
            $display("servo_slew_ramp regression: pass");
        else
            $display("servo_slew_ramp regression: fail");
        $finish;
    end

endmodule

>>> sim.f
src/ssr_pkg.sv
src/ssr_map.sv
src/ssr_slew.sv
src/ssr_cell.sv
src/servo_slew_ramp.sv
tb/testbench.sv
